FILE: design/eat_pkg.sv
// Types and constants shared by the escaped argument tokenizer and its checker.
`timescale 1ns / 1ps
`default_nettype none

package eat_pkg;

   typedef struct packed {
      logic [7:0] byte_req;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] char_value;
      logic [1:0] error_code;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_ESCAPE = 3'd1,
      MODE_OCTAL  = 3'd2,
      MODE_HALTED = 3'd3
   } mode_type;

   localparam logic [1:0] KIND_CHAR     = 2'd0;
   localparam logic [1:0] KIND_END_ARG  = 2'd1;
   localparam logic [1:0] KIND_END_LIST = 2'd2;
   localparam logic [1:0] KIND_ERROR    = 2'd3;

   localparam logic [1:0] ERR_BAD_OCTAL  = 2'd0;
   localparam logic [1:0] ERR_EOF_ESCAPE = 2'd1;
   localparam logic [1:0] ERR_BAD_ESCAPE = 2'd2;
   localparam logic [1:0] ERR_TAB        = 2'd3;

   localparam logic [1:0] OCTAL_DIGITS = 2'd3;

   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_SEVEN     = 8'h37;

   function automatic rsp_type make_rsp(logic [1:0] kind, logic [7:0] ch, logic [1:0] err);
      rsp_type r;
      r.kind       = kind;
      r.char_value = (kind == KIND_CHAR) ? ch : 8'd0;
      r.error_code = (kind == KIND_ERROR) ? err : 2'd0;
      r.last       = 1'b0;
      return r;
   endfunction

   // Single-character escapes; anything not listed passes through as is.
   function automatic logic [7:0] escape_code(logic [7:0] b);
      logic [7:0] c;
      case (b)
         8'h61:   c = 8'd7;   // a
         8'h62:   c = 8'd8;   // b
         8'h66:   c = 8'd12;  // f
         8'h6E:   c = 8'd10;  // n
         8'h72:   c = 8'd13;  // r
         8'h74:   c = 8'd9;   // t
         8'h76:   c = 8'd11;  // v
         default: c = b;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: design/escaped_argument_tokenizer.sv
// Escaped argument tokenizer: splits a byte stream into space-separated arguments.
// One input transfer is taken per cycle and decoded in the same cycle into zero, one or
// two results, which go into a three-entry result queue; the head of that queue drives
// rsp_data. req_ready stays high while at most one result is waiting, so with the
// consumer always ready the block sustains one byte per clock. The only item with two
// results is newline or end of input after a non-empty argument; its second result
// leaves the queue right behind the first. After end of list or an error the block still
// takes input but gives no further results until reset.
`timescale 1ns / 1ps
`default_nettype none

module escaped_argument_tokenizer
   import eat_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   mode_type   mode_ff, mode_in;
   logic [7:0] acc_ff, acc_in;
   logic [1:0] seen_ff, seen_in;
   logic       nonempty_ff, nonempty_in;

   rsp_type    q_ff [3];
   rsp_type    q_in [3];
   logic [1:0] count_ff, count_in;

   logic       push, pop;
   logic [1:0] cnt_pop;
   logic [1:0] res_n;
   rsp_type    res0, res1;
   logic [7:0] b;
   logic       eoi;
   logic       is_octal;
   logic       is_escape;
   logic [1:0] seen_next;

   assign b         = req_data.byte_req;
   assign eoi       = req_data.end_of_input;
   assign is_octal  = (b >= CH_ZERO) && (b <= CH_SEVEN);
   assign is_escape = b inside {8'h61, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74, 8'h76,
                                CH_BACKSLASH, CH_SPACE, CH_TAB, CH_NEWLINE};
   assign seen_next = 2'(seen_ff + 2'd1);

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = q_ff[0];
   assign req_ready = (count_ff <= 2'd1);
   assign push      = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;

   // Next state of the parser
   always_comb begin
      mode_in     = mode_ff;
      acc_in      = acc_ff;
      seen_in     = seen_ff;
      nonempty_in = nonempty_ff;
      if (push) begin
         case (mode_ff)
            MODE_NORMAL: begin
               if (eoi || b == CH_NEWLINE) begin
                  mode_in     = MODE_HALTED;
                  nonempty_in = 1'b0;
               end else if (b == CH_BACKSLASH) begin
                  mode_in = MODE_ESCAPE;
               end else if (b == CH_SPACE) begin
                  nonempty_in = 1'b0;
               end else if (b == CH_TAB) begin
                  mode_in = MODE_HALTED;
               end else begin
                  nonempty_in = 1'b1;
               end
            end
            MODE_ESCAPE: begin
               if (eoi) begin
                  mode_in = MODE_HALTED;
               end else if (is_escape) begin
                  mode_in     = MODE_NORMAL;
                  nonempty_in = 1'b1;
               end else if (is_octal) begin
                  mode_in = MODE_OCTAL;
                  acc_in  = {5'd0, b[2:0]};
                  seen_in = 2'd1;
               end else begin
                  mode_in = MODE_HALTED;
               end
            end
            MODE_OCTAL: begin
               if (eoi || !is_octal) begin
                  mode_in = MODE_HALTED;
               end else if (seen_next >= OCTAL_DIGITS) begin
                  mode_in     = MODE_NORMAL;
                  acc_in      = 8'd0;
                  seen_in     = 2'd0;
                  nonempty_in = 1'b1;
               end else begin
                  acc_in  = {acc_ff[4:0], b[2:0]};
                  seen_in = seen_next;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Results caused by the item on the request port
   always_comb begin
      res_n = 2'd0;
      res0  = make_rsp(KIND_CHAR, 8'd0, 2'd0);
      res1  = make_rsp(KIND_CHAR, 8'd0, 2'd0);
      case (mode_ff)
         MODE_NORMAL: begin
            if (eoi || b == CH_NEWLINE) begin
               if (nonempty_ff) begin
                  res_n = 2'd2;
                  res0  = make_rsp(KIND_END_ARG, 8'd0, 2'd0);
                  res1  = make_rsp(KIND_END_LIST, 8'd0, 2'd0);
               end else begin
                  res_n = 2'd1;
                  res0  = make_rsp(KIND_END_LIST, 8'd0, 2'd0);
               end
            end else if (b == CH_BACKSLASH) begin
               res_n = 2'd0;
            end else if (b == CH_SPACE) begin
               res_n = 2'd1;
               res0  = make_rsp(KIND_END_ARG, 8'd0, 2'd0);
            end else if (b == CH_TAB) begin
               res_n = 2'd1;
               res0  = make_rsp(KIND_ERROR, 8'd0, ERR_TAB);
            end else begin
               res_n = 2'd1;
               res0  = make_rsp(KIND_CHAR, b, 2'd0);
            end
         end
         MODE_ESCAPE: begin
            if (eoi) begin
               res_n = 2'd1;
               res0  = make_rsp(KIND_ERROR, 8'd0, ERR_EOF_ESCAPE);
            end else if (is_escape) begin
               res_n = 2'd1;
               res0  = make_rsp(KIND_CHAR, escape_code(b), 2'd0);
            end else if (!is_octal) begin
               res_n = 2'd1;
               res0  = make_rsp(KIND_ERROR, 8'd0, ERR_BAD_ESCAPE);
            end
         end
         MODE_OCTAL: begin
            if (eoi || !is_octal) begin
               res_n = 2'd1;
               res0  = make_rsp(KIND_ERROR, 8'd0, ERR_BAD_OCTAL);
            end else if (seen_next >= OCTAL_DIGITS) begin
               res_n = 2'd1;
               res0  = make_rsp(KIND_CHAR, {acc_ff[4:0], b[2:0]}, 2'd0);
            end
         end
         default: begin
         end
      endcase
      if (res_n == 2'd1) begin
         res0.last = 1'b1;
      end
      if (res_n == 2'd2) begin
         res1.last = 1'b1;
      end
   end

   // Result queue: drop the head on a transfer, then append this cycle's results
   always_comb begin
      cnt_pop = 2'(count_ff - {1'b0, pop});
      q_in[0] = pop ? q_ff[1] : q_ff[0];
      q_in[1] = pop ? q_ff[2] : q_ff[1];
      q_in[2] = q_ff[2];
      for (int i = 0; i < 3; i++) begin
         if (push && res_n != 2'd0 && 2'(i) == cnt_pop) begin
            q_in[i] = res0;
         end
         if (push && res_n == 2'd2 && 2'(i) == 2'(cnt_pop + 2'd1)) begin
            q_in[i] = res1;
         end
      end
      count_in = push ? 2'(cnt_pop + res_n) : cnt_pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_NORMAL;
         acc_ff      <= 8'd0;
         seen_ff     <= 2'd0;
         nonempty_ff <= 1'b0;
         count_ff    <= 2'd0;
      end else begin
         mode_ff     <= mode_in;
         acc_ff      <= acc_in;
         seen_ff     <= seen_in;
         nonempty_ff <= nonempty_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

endmodule

`default_nettype wire

FILE: design/eat_checker.sv
// Port-level checks for the escaped argument tokenizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module eat_checker
   import eat_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result changed while stalled");

   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_CHAR |-> rsp_data.char_value == 8'd0)
      else $error("character value set on a mark");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_ERROR |-> rsp_data.error_code == 2'd0)
      else $error("error code set on a non-error");

   // End of list and errors are terminal: nothing may follow them
   a_silent_after_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready &&
      (rsp_data.kind == KIND_END_LIST || rsp_data.kind == KIND_ERROR) |=> !rsp_valid)
      else $error("result after end of list or error");

endmodule

bind escaped_argument_tokenizer eat_checker u_eat_checker (.*);

`default_nettype wire
